[hw/rtl/sqe_pkg.sv]
package sqe_pkg;

    // widths fixed by the stream payloads
    localparam int OP_W       = 3;
    localparam int VALUE_W    = 32;
    localparam int STATUS_W   = 2;
    localparam int CNT_W      = 7;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 48;

    // operation codes carried in the input beat
    typedef enum logic [OP_W-1:0] {
        OP_PUSH = 3'd0,
        OP_DUMP = 3'd1,
        OP_PEEK = 3'd2,
        OP_POP  = 3'd3,
        OP_SWAP = 3'd4
    } t_op;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_SHORT = 2'd3
    } t_status;

    // per-cycle command broadcast along the cell row
    typedef enum logic [2:0] {
        CELL_HOLD       = 3'd0,
        CELL_PUSH_FRONT = 3'd1,
        CELL_PUSH_BACK  = 3'd2,
        CELL_POP        = 3'd3,
        CELL_SWAP       = 3'd4,
        CELL_ROTATE     = 3'd5
    } t_cell_cmd;

    typedef struct packed {
        t_cell_cmd        cmd;
        logic [CNT_W-1:0] count;
    } t_cell_ctrl;

endpackage

[hw/rtl/sqe_cell.sv]
module sqe_cell #(
    parameter int DATA_WIDTH = 32,
    parameter int INDEX      = 0
) (
    input  logic                    i_clk,
    input  sqe_pkg::t_cell_ctrl     i_ctrl,
    input  logic [DATA_WIDTH-1:0]   i_push_data,
    input  logic [DATA_WIDTH-1:0]   i_prev,
    input  logic [DATA_WIDTH-1:0]   i_next,
    input  logic [DATA_WIDTH-1:0]   i_head,
    output logic [DATA_WIDTH-1:0]   o_data
);
    import sqe_pkg::*;

    localparam logic [CNT_W-1:0] MY_POS = CNT_W'(INDEX);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;

    // pick the new entry from neighbors, the push bus or the head
    always_comb begin
        n_data = r_data;
        case (i_ctrl.cmd)
            CELL_HOLD: begin
                n_data = r_data;
            end
            CELL_PUSH_FRONT: begin
                n_data = (INDEX == 0) ? i_push_data : i_prev;
            end
            CELL_PUSH_BACK: begin
                if (i_ctrl.count == MY_POS) begin
                    n_data = i_push_data;
                end
            end
            CELL_POP: begin
                n_data = i_next;
            end
            CELL_SWAP: begin
                if (INDEX == 0) begin
                    n_data = i_next;
                end else if (INDEX == 1) begin
                    n_data = i_prev;
                end
            end
            CELL_ROTATE: begin
                n_data = (i_ctrl.count - CNT_W'(1) == MY_POS) ? i_head : i_next;
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

[hw/rtl/stack_queue_engine.sv]
// stack_queue_engine: bounded stack or queue of signed values in a row of cells.
// input beats on s_axis: tdata holds op (3 bits) and push_value (32 bits).
// results on m_axis: tdata holds value, status and entry_count; tlast marks the
// final result of an operation. the front entry always sits in cell 0, so push,
// pop, peek and swap each return one result beat, valid in the cycle after the
// input beat. dump rotates the whole row one place per cycle while the receiver
// is ready and emits one beat per entry; the input stays closed from the
// accepting beat until the last entry beat is registered, including any
// receiver stalls, and the dump leaves the row in its original order.
// i_cfg_wr_en with i_cfg_wr_data[0] selects queue mode (push at back) or stack
// mode (push at front); write it only while idle.
// while idle, a new input beat is taken whenever the output register is empty or
// being drained, so back-to-back single-result ops run at one beat per cycle.
// a stalled receiver holds the result beat and the block takes nothing more.
// reset (synchronous, active low) empties the store and selects stack mode;
// entries themselves are not cleared and are read only after being written.
module stack_queue_engine #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic                            i_cfg_wr_data,  // queue_mode
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [2:0] op, [34:3] push_value, [39:35] zero
    input  logic [sqe_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [31:0] value, [33:32] status, [40:34] entry_count, [47:41] zero
    output logic [sqe_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    output logic                            m_axis_tlast
);
    import sqe_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic {
        S_IDLE,
        S_DUMP
    } t_state;

    t_state                 r_state;
    logic [CW-1:0]          r_count;
    logic [CW-1:0]          n_count;
    logic [CW-1:0]          r_dump_idx;
    logic                   r_queue_mode;
    logic                   r_m_valid;
    logic [VALUE_W-1:0]     r_value;
    t_status                r_status;
    logic                   r_last;
    logic [CNT_W-1:0]       r_entry_count;

    logic                   w_out_free;
    logic                   w_in_acc;
    t_op                    w_op;
    logic [DATA_WIDTH-1:0]  w_push_data;
    logic [DATA_WIDTH-1:0]  w_cell_q [DEPTH];
    logic [VALUE_W-1:0]     w_head_value;
    logic                   w_full;
    logic                   w_empty;
    logic                   w_two;
    logic                   w_dump_last;
    t_status                w_status;
    logic [VALUE_W-1:0]     w_value;
    t_cell_ctrl             w_ctrl;

    // input decode and handshake
    assign w_out_free    = !r_m_valid || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) && w_out_free;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_op          = t_op'(s_axis_tdata[OP_W-1:0]);
    assign w_push_data   = DATA_WIDTH'(signed'(s_axis_tdata[OP_W +: VALUE_W]));
    assign w_head_value  = VALUE_W'(signed'(w_cell_q[0]));

    assign w_full      = (r_count == CW'(DEPTH));
    assign w_empty     = (r_count == '0);
    assign w_two       = (r_count >= CW'(2));
    assign w_dump_last = (r_dump_idx == r_count - CW'(1));

    // operation result and cell command
    always_comb begin
        w_ctrl.cmd   = CELL_HOLD;
        w_ctrl.count = CNT_W'(r_count);
        n_count      = r_count;
        w_status     = ST_OK;
        w_value      = '0;
        if (w_in_acc) begin
            case (w_op)
                OP_PUSH: begin
                    if (w_full) begin
                        w_status = ST_FULL;
                    end else begin
                        w_ctrl.cmd = r_queue_mode ? CELL_PUSH_BACK : CELL_PUSH_FRONT;
                        n_count    = r_count + CW'(1);
                    end
                end
                OP_DUMP: begin
                    if (w_empty) begin
                        w_status = ST_EMPTY;
                    end
                end
                OP_PEEK: begin
                    if (w_empty) begin
                        w_status = ST_EMPTY;
                    end else begin
                        w_value = w_head_value;
                    end
                end
                OP_POP: begin
                    if (w_empty) begin
                        w_status = ST_EMPTY;
                    end else begin
                        w_ctrl.cmd = CELL_POP;
                        n_count    = r_count - CW'(1);
                    end
                end
                OP_SWAP: begin
                    if (!w_two) begin
                        w_status = ST_SHORT;
                    end else begin
                        w_ctrl.cmd = CELL_SWAP;
                    end
                end
                default: begin
                    w_status = ST_OK;
                end
            endcase
        end else if (r_state == S_DUMP && w_out_free) begin
            w_ctrl.cmd = CELL_ROTATE;
        end
    end

    // state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_dump_idx   <= '0;
            r_queue_mode <= 1'b0;
            r_m_valid    <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_queue_mode <= i_cfg_wr_data;
            end
            if (r_m_valid && m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_count <= n_count;
                        if (w_op == OP_DUMP && !w_empty) begin
                            r_state    <= S_DUMP;
                            r_dump_idx <= '0;
                        end else begin
                            r_m_valid     <= 1'b1;
                            r_value       <= w_value;
                            r_status      <= w_status;
                            r_last        <= 1'b1;
                            r_entry_count <= CNT_W'(n_count);
                        end
                    end
                end
                S_DUMP: begin
                    if (w_out_free) begin
                        r_m_valid     <= 1'b1;
                        r_value       <= w_head_value;
                        r_status      <= ST_OK;
                        r_last        <= w_dump_last;
                        r_entry_count <= CNT_W'(r_count);
                        r_dump_idx    <= r_dump_idx + CW'(1);
                        if (w_dump_last) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // row of entry cells, front at cell 0
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        logic [DATA_WIDTH-1:0] w_prev;
        logic [DATA_WIDTH-1:0] w_next;
        if (gi == 0) begin : g_first
            assign w_prev = w_push_data;
        end else begin : g_mid
            assign w_prev = w_cell_q[gi-1];
        end
        if (gi == DEPTH - 1) begin : g_last
            assign w_next = w_cell_q[gi];
        end else begin : g_inner
            assign w_next = w_cell_q[gi+1];
        end
        sqe_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .INDEX      (gi)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (w_ctrl),
            .i_push_data (w_push_data),
            .i_prev      (w_prev),
            .i_next      (w_next),
            .i_head      (w_cell_q[0]),
            .o_data      (w_cell_q[gi])
        );
    end

    // output beat
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tlast  = r_last;
    assign m_axis_tdata  = {{(M_TDATA_W - VALUE_W - STATUS_W - CNT_W){1'b0}},
                            r_entry_count, r_status, r_value};

endmodule

[bench/tb_stack_queue_engine.sv]
module tb_stack_queue_engine;
    import sqe_pkg::*;

    localparam int STORE_DEPTH = 64;
    localparam int IDX_W = 6;
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int RAND_PER_PHASE = 27;
    localparam int NUM_PHASES = 6;

    // op codes the block has no name for; each still returns one ok beat
    localparam logic [OP_W-1:0] OP_RSVD_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_RSVD_LAST = 3'd7;

    // queue_mode register values
    localparam logic MODE_STACK = 1'b0;
    localparam logic MODE_QUEUE = 1'b1;

    typedef struct {
        logic signed [VALUE_W-1:0] value;
        logic [STATUS_W-1:0] status;
        logic last;
        logic [CNT_W-1:0] entry_count;
    } t_result;

    // shadow copy of the deque plus the result beats it still owes
    class deque_shadow;
        logic signed [VALUE_W-1:0] cells [STORE_DEPTH];
        logic [IDX_W-1:0] front;
        logic [CNT_W-1:0] used;
        logic queue_mode;
        t_result owed_results[$];
        int errors;

        function new();
            front = '0;
            used = '0;
            queue_mode = MODE_STACK;
            errors = 0;
        endfunction

        function void owe(logic signed [VALUE_W-1:0] value, logic [STATUS_W-1:0] status,
                          logic last);
            t_result r;
            r.value = value;
            r.status = status;
            r.last = last;
            r.entry_count = used;
            owed_results.push_back(r);
        endfunction

        // update the shadow store for one accepted input beat
        function void apply_op(logic [OP_W-1:0] op, logic signed [VALUE_W-1:0] value);
            logic [IDX_W-1:0] idx;
            logic [IDX_W-1:0] nxt;
            logic signed [VALUE_W-1:0] tmp;
            nxt = front + 6'd1;
            case (op)
                OP_PUSH: begin
                    if (used >= STORE_DEPTH) begin
                        owe('0, ST_FULL, 1'b1);
                    end else begin
                        if (queue_mode == MODE_QUEUE) begin
                            idx = front + used[IDX_W-1:0];
                            cells[idx] = value;
                        end else begin
                            front = front - 6'd1;
                            cells[front] = value;
                        end
                        used = used + 7'd1;
                        owe('0, ST_OK, 1'b1);
                    end
                end
                OP_DUMP: begin
                    if (used == 0) begin
                        owe('0, ST_EMPTY, 1'b1);
                    end else begin
                        for (int i = 0; i < used; i++) begin
                            idx = front + IDX_W'(i);
                            owe(cells[idx], ST_OK, (i + 1 == used));
                        end
                    end
                end
                OP_PEEK: begin
                    if (used == 0) owe('0, ST_EMPTY, 1'b1);
                    else owe(cells[front], ST_OK, 1'b1);
                end
                OP_POP: begin
                    if (used == 0) begin
                        owe('0, ST_EMPTY, 1'b1);
                    end else begin
                        front = nxt;
                        used = used - 7'd1;
                        owe('0, ST_OK, 1'b1);
                    end
                end
                OP_SWAP: begin
                    if (used < 2) begin
                        owe('0, ST_SHORT, 1'b1);
                    end else begin
                        tmp = cells[front];
                        cells[front] = cells[nxt];
                        cells[nxt] = tmp;
                        owe('0, ST_OK, 1'b1);
                    end
                end
                default: owe('0, ST_OK, 1'b1);
            endcase
        endfunction

        // compare one output beat against the oldest owed result
        function void match_result(logic [M_TDATA_W-1:0] data, logic tlast);
            t_result want;
            logic signed [VALUE_W-1:0] got_value;
            logic [STATUS_W-1:0] got_status;
            logic [CNT_W-1:0] got_count;
            got_value = data[31:0];
            got_status = data[33:32];
            got_count = data[40:34];
            if (owed_results.size() == 0) begin
                $error("unexpected result beat: tdata %h tlast %b", data, tlast);
                errors++;
                return;
            end
            want = owed_results.pop_front();
            if (got_value !== want.value) begin
                $error("value: expected %0d, got %0d", want.value, got_value);
                errors++;
            end
            if (got_status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got_status);
                errors++;
            end
            if (tlast !== want.last) begin
                $error("last: expected %b, got %b", want.last, tlast);
                errors++;
            end
            if (got_count !== want.entry_count) begin
                $error("entry_count: expected %0d, got %0d", want.entry_count, got_count);
                errors++;
            end
        endfunction

        function int pending();
            return owed_results.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic cfg_wr_en = 1'b0;
    logic cfg_wr_data = 1'b0;
    logic in_valid = 1'b0;
    logic [S_TDATA_W-1:0] in_data = '0;
    logic out_ready = 1'b0;
    logic in_ready;
    logic out_valid;
    logic [M_TDATA_W-1:0] out_data;
    logic out_last;
    int cycles = 0;
    deque_shadow shadow;

    stack_queue_engine u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .s_axis_tvalid (in_valid),
        .s_axis_tready (in_ready),
        .s_axis_tdata  (in_data),   // [2:0] op, [34:3] push_value, [39:35] zero
        .m_axis_tvalid (out_valid),
        .m_axis_tready (out_ready),
        .m_axis_tdata  (out_data),  // [31:0] value, [33:32] status, [40:34] entry_count
        .m_axis_tlast  (out_last)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [OP_W-1:0] pick_op(int push_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < push_pct) return OP_PUSH;
        if (r < push_pct + 8) return OP_DUMP;
        if (r >= 95) return OP_W'($urandom_range(OP_RSVD_FIRST, OP_RSVD_LAST));
        case (r % 3)
            0: return OP_PEEK;
            1: return OP_POP;
            default: return OP_SWAP;
        endcase
    endfunction

    // send one input beat, then note it in the shadow once accepted
    task automatic send_op(logic [OP_W-1:0] op, logic [VALUE_W-1:0] value);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_data <= {5'b0, value, op};
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        shadow.apply_op(op, value);
    endtask

    // stop sending and wait for every owed beat plus a short settle
    task automatic drain();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (shadow.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // mode register write, only with the block idle
    task automatic set_mode(logic mode);
        drain();
        @(negedge i_clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= mode;
        @(negedge i_clk);
        cfg_wr_en <= 1'b0;
        shadow.queue_mode = mode;
    endtask

    // receiver: random stalls, then ready stretches
    initial begin
        int gap;
        int run;
        forever begin
            gap = pick_gap();
            run = $urandom_range(1, 40);
            if (gap > 0) begin
                @(negedge i_clk);
                out_ready <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            out_ready <= 1'b1;
            repeat (run - 1) @(negedge i_clk);
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && out_ready) shadow.match_result(out_data, out_last);
    end

    // hang guard
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("stack_queue_engine verification failed");
            $finish;
        end
    end

    // main sequence
    initial begin
        int push_pct;
        shadow = new();
        i_rst_n = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // stack mode: empty cases, extremes, reserved ops
        set_mode(MODE_STACK);
        send_op(OP_POP, 32'h0);
        send_op(OP_PEEK, 32'h0);
        send_op(OP_SWAP, 32'h0);
        send_op(OP_DUMP, 32'h0);
        send_op(OP_PUSH, 32'h7fff_ffff);
        send_op(OP_SWAP, 32'h0);
        send_op(OP_PUSH, 32'h8000_0000);
        send_op(OP_PUSH, 32'hffff_ffff);
        send_op(OP_PEEK, 32'h0);
        send_op(OP_SWAP, 32'h0);
        send_op(OP_DUMP, 32'h0);
        for (int o = OP_RSVD_FIRST; o <= OP_RSVD_LAST; o++) begin
            send_op(OP_W'(o), 32'hffff_ffff);
        end
        repeat (4) send_op(OP_POP, 32'h0);

        // queue mode: order of back pushes
        set_mode(MODE_QUEUE);
        send_op(OP_PUSH, 32'h0000_0001);
        send_op(OP_PUSH, 32'hffff_fffe);
        send_op(OP_PUSH, pick_value());
        send_op(OP_SWAP, 32'h0);
        send_op(OP_PEEK, 32'h0);
        send_op(OP_DUMP, 32'h0);

        // random phases, alternating modes, with fill and drain runs
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            set_mode((phase % 2 == 0) ? MODE_STACK : MODE_QUEUE);
            push_pct = (phase % 2 == 0) ? 35 : 55;
            if (phase == 1 || phase == 4) begin
                while (shadow.used < STORE_DEPTH) send_op(OP_PUSH, pick_value());
                repeat (2) send_op(OP_PUSH, pick_value());
                send_op(OP_DUMP, pick_value());
                send_op(OP_SWAP, pick_value());
                send_op(OP_PEEK, pick_value());
            end
            if (phase == 2 || phase == 5) begin
                while (shadow.used > 0) send_op(OP_POP, pick_value());
                send_op(OP_POP, pick_value());
            end
            repeat (RAND_PER_PHASE) send_op(pick_op(push_pct), pick_value());
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (shadow.errors == 0) begin
            $display("stack_queue_engine verification clean");
        end else begin
            $display("stack_queue_engine verification failed");
        end
        $finish;
    end

endmodule
